// ===== rtl/core/sil_pkg.sv =====
// Package for the sorted insert list: item types, op and status codes,
// default depth. No dependencies.
package sil_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 6;
  localparam int CNT_W     = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_DUMP   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]        position;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                    last;
    logic [1:0]              status;
    logic [CNT_W-1:0]        count;
  } out_item_t;

endpackage

// ===== rtl/core/sil_store.sv =====
// Entry store for the sorted insert list: one write port, one read port,
// registered read data. Depends on sil_pkg.
module sil_store #(
  parameter int DEPTH = sil_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [sil_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [sil_pkg::DATA_W-1:0] rdata
);
  import sil_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/sorted_insert_list.sv =====
// Sorted insert list: keeps up to DEPTH signed 32-bit values in ascending
// order in a single-port-read store walked by one compare unit. Depends on
// sil_pkg and sil_store.
//
// User notes: an item is taken when start is high and busy is low; busy
// stays high until the item's work is done. Results appear on out_item for
// one cycle with out_valid high and cannot be held off. Every store access
// is a read with a registered result followed by a compare, a write or an
// output. An insert walks down from the top entry, moving up one place
// each stored entry greater than or equal to the value; a remove at
// position p moves each entry above p down one place; a dump gives one
// result per stored entry, in ascending order. Rejected items, inserts
// into an empty list and unused op codes never raise busy.
module sorted_insert_list #(
  parameter int DEPTH = sil_pkg::DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sil_pkg::in_item_t  in_item,
  output logic               out_valid,
  output sil_pkg::out_item_t out_item
);
  import sil_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_INS_FIN = 3'd3;
  localparam logic [2:0] S_REM_RD  = 3'd4;
  localparam logic [2:0] S_REM_GET = 3'd5;
  localparam logic [2:0] S_SH_RD   = 3'd6;
  localparam logic [2:0] S_SH_WR   = 3'd7;
  localparam logic [2:0] S_DMP_RD  = 3'd1;

  logic [2:0]        state_r, state_nxt;
  logic              dump_r, dump_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic [DATA_W-1:0] held_r, held_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;
  logic              ge;
  logic [CW-1:0]     idx_ext;

  sil_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // compare unit, used by inserts
  assign ge      = $signed(rdata) >= $signed(value_r);
  assign idx_ext = CW'(idx_r);

  always_comb begin
    state_nxt     = state_r;
    dump_nxt      = dump_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    value_nxt     = value_r;
    held_nxt      = held_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = value_r;
    raddr         = idx_r;

    case (state_r)
      S_IDLE: begin
        dump_nxt = 1'b0;
        if (start) begin
          value_nxt = in_item.value;
          case (in_item.op)
            OP_INSERT: begin
              if (count_r >= CW'(DEPTH)) begin
                out_valid_nxt = 1'b1;
                out_nxt = '{data: in_item.value, last: 1'b1, status: ST_FULL,
                            count: CNT_W'(count_r)};
              end else if (count_r == '0) begin
                we        = 1'b1;
                waddr     = '0;
                wdata     = in_item.value;
                count_nxt = CW'(1);
                out_valid_nxt = 1'b1;
                out_nxt = '{data: in_item.value, last: 1'b1, status: ST_OK,
                            count: CNT_W'(1)};
              end else begin
                idx_nxt   = AW'(count_r - CW'(1));
                state_nxt = S_INS_RD;
              end
            end
            OP_REMOVE: begin
              if (CNT_W'(in_item.position) >= CNT_W'(count_r)) begin
                out_valid_nxt = 1'b1;
                out_nxt = '{data: '0, last: 1'b1, status: ST_NONE,
                            count: CNT_W'(count_r)};
              end else begin
                idx_nxt   = AW'(in_item.position);
                state_nxt = S_REM_RD;
              end
            end
            OP_DUMP: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt = '{data: '0, last: 1'b1, status: ST_NONE,
                            count: '0};
              end else begin
                idx_nxt   = '0;
                dump_nxt  = 1'b1;
                state_nxt = S_DMP_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (dump_r) begin
          state_nxt = S_INS_CMP;
        end else begin
          state_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (dump_r) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{data: rdata, last: (idx_ext + CW'(1) == count_r),
                      status: ST_OK, count: CNT_W'(count_r)};
          if (idx_ext + CW'(1) == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_INS_RD;
          end
        end else if (ge) begin
          we    = 1'b1;
          waddr = idx_r + AW'(1);
          wdata = rdata;
          if (idx_r == '0) begin
            state_nxt = S_INS_FIN;
          end else begin
            idx_nxt   = idx_r - AW'(1);
            state_nxt = S_INS_RD;
          end
        end else begin
          we        = 1'b1;
          waddr     = idx_r + AW'(1);
          wdata     = value_r;
          count_nxt = count_r + CW'(1);
          out_valid_nxt = 1'b1;
          out_nxt = '{data: value_r, last: 1'b1, status: ST_OK,
                      count: CNT_W'(count_r + CW'(1))};
          state_nxt = S_IDLE;
        end
      end
      S_INS_FIN: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = value_r;
        count_nxt = count_r + CW'(1);
        out_valid_nxt = 1'b1;
        out_nxt = '{data: value_r, last: 1'b1, status: ST_OK,
                    count: CNT_W'(count_r + CW'(1))};
        state_nxt = S_IDLE;
      end
      S_REM_RD: begin
        state_nxt = S_REM_GET;
      end
      S_REM_GET: begin
        held_nxt = rdata;
        if (idx_ext + CW'(1) == count_r) begin
          count_nxt = count_r - CW'(1);
          out_valid_nxt = 1'b1;
          out_nxt = '{data: rdata, last: 1'b1, status: ST_OK,
                      count: CNT_W'(count_r - CW'(1))};
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SH_RD;
        end
      end
      S_SH_RD: begin
        raddr     = idx_r + AW'(1);
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        we    = 1'b1;
        waddr = idx_r;
        wdata = rdata;
        if (idx_ext + CW'(2) == count_r) begin
          count_nxt = count_r - CW'(1);
          out_valid_nxt = 1'b1;
          out_nxt = '{data: held_r, last: 1'b1, status: ST_OK,
                      count: CNT_W'(count_r - CW'(1))};
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_SH_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dump_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dump_r      <= dump_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    value_r <= value_nxt;
    held_r  <= held_nxt;
    out_r   <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/core/sil_checker.sv =====
// Port-level checks for the sorted insert list, bound to the top level.
// Depends on sil_pkg and sorted_insert_list.
module sil_checker #(
  parameter int DEPTH = sil_pkg::DEPTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input sil_pkg::in_item_t  in_item,
  input logic               out_valid,
  input sil_pkg::out_item_t out_item
);
  import sil_pkg::*;

  // unused op codes produce nothing
  a_op3_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_item.op == OP_UNUSED) |=> !out_valid)
    else $error("result after unused op");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != ST_OK) |-> out_item.last)
    else $error("error result not marked last");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_FULL) |-> (out_item.count == CNT_W'(DEPTH)))
    else $error("full flag with list not full");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> !busy)
    else $error("busy after final result");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy)
    else $error("idle during dump");

endmodule

bind sorted_insert_list sil_checker #(.DEPTH(DEPTH)) u_sil_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
